>>> hw/rtl/tlvp_pkg.sv
// Package with the constants, codes and result type of the TLV byte parser.
`timescale 1ns / 1ps

package tlvp_pkg;

  localparam int unsigned MaxTlvs     = 8;
  localparam int unsigned MaxValueLen = 16;
  localparam int unsigned NodeTypeShift = 5;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned KindW  = 3;
  localparam int unsigned TidxW  = 3;
  localparam int unsigned VidxW  = 4;
  localparam int unsigned NtypeW = ByteW - NodeTypeShift;

  // Counter widths follow from the bounds so that the bound itself fits.
  localparam int unsigned TlvsLeftW = $clog2(MaxTlvs + 1);
  localparam int unsigned ValLeftW  = $clog2(MaxValueLen + 1);

  localparam logic [KindW-1:0] KindPrefix = 3'd0;
  localparam logic [KindW-1:0] KindNode   = 3'd1;
  localparam logic [KindW-1:0] KindCount  = 3'd2;
  localparam logic [KindW-1:0] KindTag    = 3'd3;
  localparam logic [KindW-1:0] KindLength = 3'd4;
  localparam logic [KindW-1:0] KindValue  = 3'd5;

  typedef struct packed {
    logic [KindW-1:0]  field_kind;
    logic [ByteW-1:0]  byte_out;
    logic [TidxW-1:0]  tlv_index;
    logic [VidxW-1:0]  value_index;
    logic [NtypeW-1:0] node_type;
    logic              message_end;
    logic              size_error;
  } result_t;

endpackage

>>> hw/rtl/tlvp_if.sv
// Handshake interfaces for the byte input and the classified result output.
`timescale 1ns / 1ps

interface tlvp_in_if;
  logic                      valid;
  logic                      ready;
  logic [tlvp_pkg::ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface tlvp_out_if;
  logic                       valid;
  logic                       ready;
  logic [tlvp_pkg::KindW-1:0]  field_kind;
  logic [tlvp_pkg::ByteW-1:0]  byte_out;
  logic [tlvp_pkg::TidxW-1:0]  tlv_index;
  logic [tlvp_pkg::VidxW-1:0]  value_index;
  logic [tlvp_pkg::NtypeW-1:0] node_type;
  logic                        message_end;
  logic                        size_error;

  modport source (output valid, output field_kind, output byte_out, output tlv_index,
                  output value_index, output node_type, output message_end,
                  output size_error, input ready);
  modport sink (input valid, input field_kind, input byte_out, input tlv_index,
                input value_index, input node_type, input message_end,
                input size_error, output ready);
endinterface

>>> hw/rtl/tlvp_classifier.sv
// Parse state registers and the per-byte classification logic.
`timescale 1ns / 1ps

module tlvp_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [tlvp_pkg::ByteW-1:0] data_byte_i,
  output tlvp_pkg::result_t          result_o
);
  import tlvp_pkg::*;

  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhNode   = 3'd1,
    PhCount  = 3'd2,
    PhTag    = 3'd3,
    PhLen    = 3'd4,
    PhValue  = 3'd5
  } phase_e;

  localparam logic [ByteW:0] CountLimit = (ByteW + 1)'(MaxTlvs);
  localparam logic [ByteW:0] LenLimit   = (ByteW + 1)'(MaxValueLen);

  phase_e               phase_q, phase_d;
  logic [TlvsLeftW-1:0] tlvs_left_q, tlvs_left_d;
  logic [ValLeftW-1:0]  val_left_q, val_left_d;
  logic [TidxW-1:0]     cur_tlv_q, cur_tlv_d;
  logic [VidxW-1:0]     val_pos_q, val_pos_d;

  logic [TlvsLeftW-1:0] tlvs_dec;
  logic [ValLeftW-1:0]  val_dec;
  logic                 last_tlv;

  // Closing a TLV never lets the counter wrap below zero.
  assign tlvs_dec = (tlvs_left_q != '0) ? tlvs_left_q - TlvsLeftW'(1) : tlvs_left_q;
  assign val_dec  = (val_left_q != '0) ? val_left_q - ValLeftW'(1) : val_left_q;
  assign last_tlv = (tlvs_dec == '0);

  always_comb begin
    phase_d     = phase_q;
    tlvs_left_d = tlvs_left_q;
    val_left_d  = val_left_q;
    cur_tlv_d   = cur_tlv_q;
    val_pos_d   = val_pos_q;
    result_o    = '0;
    result_o.byte_out = data_byte_i;

    unique case (phase_q)
      PhNode: begin
        result_o.field_kind = KindNode;
        result_o.node_type  = data_byte_i[ByteW-1:NodeTypeShift];
        phase_d = PhCount;
      end
      PhCount: begin
        result_o.field_kind = KindCount;
        if ({1'b0, data_byte_i} > CountLimit) begin
          result_o.size_error  = 1'b1;
          result_o.message_end = 1'b1;
          phase_d = PhPrefix;
        end else if (data_byte_i == '0) begin
          result_o.message_end = 1'b1;
          phase_d = PhPrefix;
        end else begin
          tlvs_left_d = data_byte_i[TlvsLeftW-1:0];
          cur_tlv_d   = '0;
          phase_d     = PhTag;
        end
      end
      PhTag: begin
        result_o.field_kind = KindTag;
        result_o.tlv_index  = cur_tlv_q;
        phase_d = PhLen;
      end
      PhLen: begin
        result_o.field_kind = KindLength;
        result_o.tlv_index  = cur_tlv_q;
        if ({1'b0, data_byte_i} > LenLimit) begin
          result_o.size_error  = 1'b1;
          result_o.message_end = 1'b1;
          phase_d = PhPrefix;
        end else if (data_byte_i == '0) begin
          // An empty value closes its TLV right on the length byte.
          tlvs_left_d = tlvs_dec;
          result_o.message_end = last_tlv;
          if (last_tlv) begin
            phase_d = PhPrefix;
          end else begin
            cur_tlv_d = cur_tlv_q + TidxW'(1);
            phase_d   = PhTag;
          end
        end else begin
          val_left_d = data_byte_i[ValLeftW-1:0];
          val_pos_d  = '0;
          phase_d    = PhValue;
        end
      end
      PhValue: begin
        result_o.field_kind  = KindValue;
        result_o.tlv_index   = cur_tlv_q;
        result_o.value_index = val_pos_q;
        val_pos_d  = val_pos_q + VidxW'(1);
        val_left_d = val_dec;
        if (val_dec == '0) begin
          tlvs_left_d = tlvs_dec;
          result_o.message_end = last_tlv;
          if (last_tlv) begin
            phase_d = PhPrefix;
          end else begin
            cur_tlv_d = cur_tlv_q + TidxW'(1);
            phase_d   = PhTag;
          end
        end
      end
      default: begin
        // Prefix byte, taken whatever its value; unused codes behave the same.
        result_o.field_kind = KindPrefix;
        phase_d = PhNode;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhPrefix;
      tlvs_left_q <= '0;
      val_left_q  <= '0;
      cur_tlv_q   <= '0;
      val_pos_q   <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      tlvs_left_q <= tlvs_left_d;
      val_left_q  <= val_left_d;
      cur_tlv_q   <= cur_tlv_d;
      val_pos_q   <= val_pos_d;
    end
  end

endmodule

>>> hw/rtl/tlvp_out_reg.sv
// Result register that holds one classified item until the receiver takes it.
`timescale 1ns / 1ps

module tlvp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  tlvp_pkg::result_t result_i,
  input  logic              take_i,
  output logic              valid_o,
  output logic              free_o,
  output tlvp_pkg::result_t result_o
);
  import tlvp_pkg::*;

  logic    valid_q;
  result_t data_q;

  // The slot is free when empty or when its item leaves in this cycle.
  assign free_o   = !valid_q || take_i;
  assign valid_o  = valid_q;
  assign result_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

>>> hw/rtl/tlv_message_byte_parser_core.sv
// Top level of the TLV message byte parser.
`timescale 1ns / 1ps
//
// The block classifies a stream of message bytes, one item per byte. A message
// is a prefix byte, a node-id byte and a TLV count, then per TLV a tag byte, a
// length byte and that many value bytes. Each byte on in_i yields exactly one
// item on out_o with its kind, the byte itself, TLV and value positions, the
// node type on the node-id byte, and end-of-message and size-error flags.
// A count or length above its bound raises the error and ends the message.
// An item accepted at an edge is registered and is on out_o after that edge.
// Throughput is one item per cycle while out_o does not stall, set by the
// parse-state registers, which update on each accepted byte, and the result
// register behind them. When out_o stalls, the held item stays and in_i.ready
// falls until it is taken; a new byte is accepted in the same cycle the held
// item leaves. Reset empties the result register and returns the parser to
// expect a prefix byte with all counters cleared.
//
module tlv_message_byte_parser_core (
  input logic    clk_i,
  input logic    rst_ni,
  tlvp_in_if.sink    in_i,
  tlvp_out_if.source out_o
);
  import tlvp_pkg::*;

  logic    accept;
  logic    free;
  result_t cls_result;
  result_t held_result;

  assign in_i.ready = free;
  assign accept     = in_i.valid && free;

  tlvp_classifier u_classifier (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .result_o    (cls_result)
  );

  tlvp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (accept),
    .result_i (cls_result),
    .take_i   (out_o.ready),
    .valid_o  (out_o.valid),
    .free_o   (free),
    .result_o (held_result)
  );

  assign out_o.field_kind  = held_result.field_kind;
  assign out_o.byte_out    = held_result.byte_out;
  assign out_o.tlv_index   = held_result.tlv_index;
  assign out_o.value_index = held_result.value_index;
  assign out_o.node_type   = held_result.node_type;
  assign out_o.message_end = held_result.message_end;
  assign out_o.size_error  = held_result.size_error;

endmodule

>>> verif/tb_tlv_message_byte_parser_core.sv
// Self-checking testbench for the TLV message byte parser core.
`timescale 1ns / 1ps

module tb_tlv_message_byte_parser_core;
  import tlvp_pkg::*;

  localparam int unsigned RandomBytes  = 850;
  localparam int unsigned StallLimit   = 1000;
  localparam int unsigned LongHoldOff  = 80;
  localparam int unsigned HoldOffAt    = 300;
  localparam int unsigned DrainAtFirst = 20;
  localparam int unsigned DrainAtMid   = 480;

  typedef enum logic [2:0] {
    PhPrefix = 3'd0,
    PhNode   = 3'd1,
    PhCount  = 3'd2,
    PhTag    = 3'd3,
    PhLen    = 3'd4,
    PhValue  = 3'd5
  } parse_phase_e;

  logic clk_i;
  logic rst_ni;

  tlvp_in_if  in_if ();
  tlvp_out_if out_if ();

  tlv_message_byte_parser_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Parser state as the block should hold it.
  parse_phase_e         parse_phase    = PhPrefix;
  logic [3:0]           tlvs_remaining = '0;
  logic [4:0]           value_remaining = '0;
  logic [TidxW-1:0]     tlv_cursor     = '0;
  logic [VidxW-1:0]     value_cursor   = '0;

  logic [ByteW-1:0] msg_bytes_q[$];
  result_t          classified_q[$];

  int  failures      = 0;
  int  bytes_sent    = 0;
  int  results_seen  = 0;
  int  idle_cycles   = 0;
  int  send_gap      = 0;
  int  take_stall    = 0;
  bit  send_burst    = 0;
  bit  take_burst    = 0;
  bit  long_hold_done = 0;
  bit  byte_accepted = 0;
  bit  result_taken  = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Returns 1 when the TLV just closed was the last one of the message.
  function automatic bit close_tlv();
    if (tlvs_remaining != 0) tlvs_remaining--;
    if (tlvs_remaining == 0) begin
      parse_phase = PhPrefix;
      return 1'b1;
    end
    tlv_cursor++;
    parse_phase = PhTag;
    return 1'b0;
  endfunction

  function automatic result_t classify_byte(input logic [ByteW-1:0] b);
    result_t r;
    r = '0;
    r.byte_out = b;
    case (parse_phase)
      PhNode: begin
        r.field_kind = KindNode;
        r.node_type  = NtypeW'(b >> NodeTypeShift);
        parse_phase  = PhCount;
      end
      PhCount: begin
        r.field_kind = KindCount;
        if (b > MaxTlvs) begin
          r.size_error  = 1'b1;
          r.message_end = 1'b1;
          parse_phase   = PhPrefix;
        end else if (b == 0) begin
          r.message_end = 1'b1;
          parse_phase   = PhPrefix;
        end else begin
          tlvs_remaining = b[3:0];
          tlv_cursor     = '0;
          parse_phase    = PhTag;
        end
      end
      PhTag: begin
        r.field_kind = KindTag;
        r.tlv_index  = tlv_cursor;
        parse_phase  = PhLen;
      end
      PhLen: begin
        r.field_kind = KindLength;
        r.tlv_index  = tlv_cursor;
        if (b > MaxValueLen) begin
          r.size_error  = 1'b1;
          r.message_end = 1'b1;
          parse_phase   = PhPrefix;
        end else if (b == 0) begin
          r.message_end = close_tlv();
        end else begin
          value_remaining = b[4:0];
          value_cursor    = '0;
          parse_phase     = PhValue;
        end
      end
      PhValue: begin
        r.field_kind  = KindValue;
        r.tlv_index   = tlv_cursor;
        r.value_index = value_cursor;
        value_cursor++;
        if (value_remaining != 0) value_remaining--;
        if (value_remaining == 0) r.message_end = close_tlv();
      end
      default: begin
        r.field_kind = KindPrefix;
        parse_phase  = PhNode;
      end
    endcase
    return r;
  endfunction

  function automatic int draw_wait(input bit burst);
    return burst ? 0 : int'($urandom_range(0, 8));
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endtask

  // Result check, prediction of accepted bytes and the watchdog.
  always @(posedge clk_i) begin
    result_t e;
    result_taken  = out_if.valid && out_if.ready;
    byte_accepted = in_if.valid && in_if.ready;
    if (result_taken) begin
      results_seen++;
      if (classified_q.size() == 0) begin
        $error("result with no byte pending: kind %0d byte %0d",
               out_if.field_kind, out_if.byte_out);
        failures++;
      end else begin
        e = classified_q.pop_front();
        check_field("field_kind", 8'(e.field_kind), 8'(out_if.field_kind));
        check_field("byte_out", e.byte_out, out_if.byte_out);
        check_field("tlv_index", 8'(e.tlv_index), 8'(out_if.tlv_index));
        check_field("value_index", 8'(e.value_index), 8'(out_if.value_index));
        check_field("node_type", 8'(e.node_type), 8'(out_if.node_type));
        check_field("message_end", 8'(e.message_end), 8'(out_if.message_end));
        check_field("size_error", 8'(e.size_error), 8'(out_if.size_error));
      end
    end
    if (byte_accepted) classified_q.push_back(classify_byte(in_if.data_byte));
    if (byte_accepted || result_taken) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("** tlv_message_byte_parser_core: FAILED **");
        $finish;
      end
    end
  end

  // Byte driver. At two points it holds off until every result is back.
  always @(negedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = in_if.valid;
      if (byte_accepted) offer = 1'b0;
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (msg_bytes_q.size() != 0 &&
                     !((bytes_sent == DrainAtFirst || bytes_sent == DrainAtMid) &&
                       classified_q.size() != 0)) begin
          in_if.data_byte <= msg_bytes_q.pop_front();
          offer = 1'b1;
          bytes_sent++;
          if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
          send_gap = draw_wait(send_burst);
        end
      end
      in_if.valid <= offer;
    end
  end

  // Result receiver, with one long hold-off while the sender keeps going.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        if ($urandom_range(0, 39) == 0) take_burst = ~take_burst;
        take_stall = draw_wait(take_burst);
      end
      if (results_seen >= HoldOffAt && !long_hold_done) begin
        take_stall     = LongHoldOff;
        long_hold_done = 1'b1;
      end
      if (take_stall > 0) begin
        out_if.ready <= 1'b0;
        take_stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic add_byte(input int b);
    msg_bytes_q.push_back(b[7:0]);
  endtask

  initial begin
    int kind_sel;
    int count;
    int len;
    int total_bytes;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    out_if.ready    = 1'b0;
    rst_ni          = 1'b0;

    // Empty message with an all-ones node id.
    add_byte(8'h00); add_byte(8'hFF); add_byte(0);
    // Count one above the bound.
    add_byte(8'hFF); add_byte(8'h00); add_byte(MaxTlvs + 1);
    // A zero-length value, then a length one above the bound.
    add_byte(8'h7E); add_byte(8'hE0); add_byte(2);
    add_byte(8'hFF); add_byte(0);
    add_byte(8'h00); add_byte(MaxValueLen + 1);
    // Single TLV with extreme value bytes, ending on a value byte.
    add_byte(8'h80); add_byte(8'h20); add_byte(1);
    add_byte(8'h55); add_byte(2); add_byte(8'h00); add_byte(8'hFF);

    while (msg_bytes_q.size() < DrainAtFirst + RandomBytes) begin
      kind_sel = $urandom_range(0, 99);
      if (kind_sel < 8) begin
        repeat ($urandom_range(1, 6)) add_byte($urandom_range(0, 255));
      end else if (kind_sel < 16) begin
        add_byte($urandom_range(0, 255));
        add_byte($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) begin
          add_byte($urandom_range(MaxTlvs + 1, 255));
        end else begin
          add_byte($urandom_range(1, MaxTlvs));
          add_byte($urandom_range(0, 255));
          add_byte($urandom_range(MaxValueLen + 1, 255));
        end
      end else begin
        add_byte($urandom_range(0, 255));
        add_byte($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0) count = 0;
        else if ($urandom_range(0, 4) == 0) count = $urandom_range(1, MaxTlvs);
        else count = $urandom_range(1, 3);
        add_byte(count);
        for (int t = 0; t < count; t++) begin
          add_byte($urandom_range(0, 255));
          if ($urandom_range(0, 5) == 0) len = $urandom_range(0, MaxValueLen);
          else len = $urandom_range(0, 4);
          add_byte(len);
          repeat (len) add_byte($urandom_range(0, 255));
        end
      end
    end
    total_bytes = msg_bytes_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every byte yields exactly one result, so the run is done once all are back.
    while (results_seen < total_bytes)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (failures == 0) begin
      $display("** tlv_message_byte_parser_core: PASSED **");
    end else begin
      $display("** tlv_message_byte_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
